### hdl/cpu_hotplug_load_governor_core_macros.svh
// Assertion macros for the checker file of the load governor.
`ifndef CPU_HOTPLUG_LOAD_GOVERNOR_CORE_MACROS_SVH
`define CPU_HOTPLUG_LOAD_GOVERNOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and quiet while reset is active.
`define CHLG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("governor check failed");

// Next-cycle implication, sampled on clk_i and quiet while reset is active.
`define CHLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("governor check failed");

`endif

### hdl/chlg_pkg.sv
package chlg_pkg;

  // Field widths.
  localparam int unsigned TASK_W   = 10;
  localparam int unsigned CORE_W   = 3;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned LOAD_W   = 17;
  localparam int unsigned AVG_W    = 17;
  localparam int unsigned DELAY_W  = 12;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned DPC_W    = 10;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned SQ_W     = 2 * CORE_W;
  localparam int unsigned DLIM_W   = DPC_W + CORE_W;
  localparam int unsigned DRAW_W   = PERIOD_W + SQ_W;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Block constants.
  localparam int unsigned RING_DEPTH_DEF = 10;
  localparam int unsigned CORE_COUNT     = 4;
  localparam int unsigned MAX_TASKS      = 1023;
  localparam int unsigned MAX_AVG        = MAX_TASKS * 100;
  localparam logic [6:0]  LOAD_SCALE     = 7'd100;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  // Register reset values.
  localparam logic [CORE_W-1:0]   MIN_ONLINE_RST = 3'd1;
  localparam logic [THR_W-1:0]    ENABLE_THR_RST = 17'd600;
  localparam logic [DPC_W-1:0]    DIS_PER_CPU_RST = 10'd60;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd1;

  // Result actions.
  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD        = 2'd0,
    ACT_ONLINE_ALL  = 2'd1,
    ACT_OFFLINE_ONE = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ONLINE  = 2'd0,
    CFG_ENABLE_THR  = 2'd1,
    CFG_DIS_PER_CPU = 2'd2,
    CFG_MIN_PERIOD  = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_QUOT,
    ST_AVG,
    ST_DECIDE
  } state_e;

endpackage

### hdl/cpu_hotplug_load_governor_core.sv
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   runnable_tasks_i, cores_online_i
// out       output     out_valid_o / out_stall_i action_o, average_load_o, next_delay_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample is taken only while the sequencer is idle, and the next sample is taken
// only after the result of the last one has been loaded.
// The sequencer handles one sample at a time: ring read, ring write with running-sum
// update, reciprocal multiply, quotient correction and decision.
// Reset clears the running sum, the write slot, the ring valid bits and the output valid flag.
// A stalled result holds in the output register; the block still takes a new sample,
// and only the decision step waits for the output register to free up.
module cpu_hotplug_load_governor_core #(
  parameter int unsigned RING_DEPTH = chlg_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [chlg_pkg::TASK_W-1:0]       runnable_tasks_i,
  input  logic [chlg_pkg::CORE_W-1:0]       cores_online_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [chlg_pkg::ACT_W-1:0]        action_o,
  output logic [chlg_pkg::AVG_W-1:0]        average_load_o,
  output logic [chlg_pkg::DELAY_W-1:0]      next_delay_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [chlg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [chlg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import chlg_pkg::*;

  localparam int unsigned SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W  = LOAD_W + $clog2(RING_DEPTH);
  localparam int unsigned PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0]  RECIP     = SUM_W'((64'd1 << SUM_W) / RING_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  state_e state_q, state_d;

  // Configuration registers.
  logic [CORE_W-1:0]   min_online_q;
  logic [THR_W-1:0]    enable_thr_q;
  logic [DPC_W-1:0]    dis_per_cpu_q;
  logic [PERIOD_W-1:0] period_q;
  logic [CORE_W-1:0]   min_online_wr;

  // Sample and datapath registers.
  logic [CORE_W-1:0]   online_q;
  logic [SQ_W-1:0]     online_sq_q;
  logic [LOAD_W-1:0]   load_q;
  logic [TASK_W-1:0]   tasks_sat;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic [AVG_W-1:0]    quot_q;
  logic [AVG_W-1:0]    avg_q;
  logic [AVG_W-1:0]    avg_d;
  logic [SUM_W-1:0]    quot_mul;
  logic [SUM_W-1:0]    rem;
  logic [DLIM_W-1:0]   dis_lim_q;
  logic [DRAW_W-1:0]   delay_raw_q;
  logic [LOAD_W-1:0]   old_load;

  // Ring memory and its bookkeeping.
  logic [LOAD_W-1:0]     ring_mem [RING_DEPTH];
  logic [LOAD_W-1:0]     ring_rdata_q;
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [SLOT_W-1:0]     slot_q;

  // Sequencer controls.
  logic in_take;
  logic ring_re;
  logic ring_we;
  logic res_load;
  logic out_free;

  // Decision.
  action_e            act;
  logic [DELAY_W-1:0] delay;

  // Output registers.
  logic               out_valid_q;
  logic [ACT_W-1:0]   action_q;
  logic [AVG_W-1:0]   avg_out_q;
  logic [DELAY_W-1:0] delay_q;

  assign cfg_ready_o    = 1'b1;
  assign in_take        = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign average_load_o = avg_out_q;
  assign next_delay_o   = delay_q;

  // Clamp of the minimum online count to one through the core count.
  always_comb begin
    min_online_wr = cfg_data_i[CORE_W-1:0];
    if (min_online_wr == '0) begin
      min_online_wr = CORE_W'(1);
    end
    if (32'(min_online_wr) > CORE_COUNT) begin
      min_online_wr = CORE_W'(CORE_COUNT);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_online_q  <= MIN_ONLINE_RST;
      enable_thr_q  <= ENABLE_THR_RST;
      dis_per_cpu_q <= DIS_PER_CPU_RST;
      period_q      <= PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_ONLINE:  min_online_q  <= min_online_wr;
        CFG_ENABLE_THR:  enable_thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_DIS_PER_CPU: dis_per_cpu_q <= cfg_data_i[DPC_W-1:0];
        CFG_MIN_PERIOD:  period_q      <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_QUOT;
      ST_QUOT:   state_d = ST_AVG;
      ST_AVG:    state_d = ST_DECIDE;
      ST_DECIDE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    res_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ring_re    = in_valid_i;
      end
      ST_UPDATE: ring_we  = 1'b1;
      ST_DECIDE: res_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Ring memory: one write port and one registered read port at the write slot.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= load_q;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[slot_q];
    end
  end

  // An entry never written reads as zero.
  assign old_load = ring_vld_q[slot_q] ? ring_rdata_q : '0;

  // Valid bits, write slot and running sum of the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      slot_q     <= '0;
      sum_q      <= '0;
    end else if (ring_we) begin
      ring_vld_q[slot_q] <= 1'b1;
      slot_q             <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
      sum_q              <= sum_q - SUM_W'(old_load) + SUM_W'(load_q);
    end
  end

  // Task count saturation.
  assign tasks_sat = (32'(runnable_tasks_i) > MAX_TASKS) ? TASK_W'(MAX_TASKS)
                                                         : runnable_tasks_i;

  // Division by the ring depth: the reciprocal product is low by at most one.
  assign quot_mul = SUM_W'(quot_q) * DEPTH_S;
  assign rem      = sum_q - quot_mul;
  assign avg_d    = (rem >= DEPTH_S) ? quot_q + AVG_W'(1) : quot_q;

  // Datapath registers, loaded in their sequencer step.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      online_q    <= cores_online_i;
      online_sq_q <= SQ_W'(cores_online_i) * SQ_W'(cores_online_i);
      load_q      <= LOAD_W'(tasks_sat) * LOAD_W'(LOAD_SCALE);
    end
    if (state_q == ST_UPDATE) begin
      dis_lim_q   <= DLIM_W'(dis_per_cpu_q) * DLIM_W'(online_q);
      delay_raw_q <= DRAW_W'(period_q) * DRAW_W'(online_sq_q);
    end
    if (state_q == ST_SCALE) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
    if (state_q == ST_QUOT) begin
      quot_q <= prod_q[SUM_W +: AVG_W];
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_d;
    end
  end

  // Action choice from the average and the thresholds.
  always_comb begin
    act   = ACT_HOLD;
    delay = '0;
    if ((avg_q >= enable_thr_q && 32'(online_q) < CORE_COUNT) ||
        online_q < min_online_q) begin
      act = ACT_ONLINE_ALL;
    end else if (avg_q < AVG_W'(dis_lim_q) && online_q > min_online_q) begin
      act = ACT_OFFLINE_ONE;
    end else begin
      delay = (delay_raw_q > DRAW_W'(DELAY_MAX)) ? DELAY_MAX : delay_raw_q[DELAY_W-1:0];
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      action_q  <= act;
      avg_out_q <= avg_q;
      delay_q   <= delay;
    end
  end

endmodule

### hdl/chlg_checker.sv
`include "cpu_hotplug_load_governor_core_macros.svh"

module chlg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [chlg_pkg::ACT_W-1:0]        action_o,
  input logic [chlg_pkg::AVG_W-1:0]        average_load_o,
  input logic [chlg_pkg::DELAY_W-1:0]      next_delay_o
);
  import chlg_pkg::*;

  // A stalled result word keeps its value.
  `CHLG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(action_o) && $stable(average_load_o) && $stable(next_delay_o))

  // Only a hold carries a resample delay.
  `CHLG_ASSERT_NOW(a_delay_hold, out_valid_o && action_o != ACT_HOLD, next_delay_o == '0)

  // The ring average never exceeds the largest scaled task count.
  `CHLG_ASSERT_NOW(a_avg_range, out_valid_o, 32'(average_load_o) <= MAX_AVG)

  // The sequencer is busy in the cycle after it takes a sample.
  `CHLG_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind cpu_hotplug_load_governor_core chlg_checker u_chlg_checker (.*);

### bench/cpu_hotplug_load_governor_core_checker.sv
`timescale 1ns / 100ps

module cpu_hotplug_load_governor_core_checker
  import chlg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [TASK_W-1:0]     runnable_tasks_i,
  input  logic [CORE_W-1:0]     cores_online_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [AVG_W-1:0]      average_load_i,
  input  logic [DELAY_W-1:0]    next_delay_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned RING_N       = RING_DEPTH_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  // One result word as the governor should emit it.
  typedef struct packed {
    action_e              act;
    logic [AVG_W-1:0]     avg;
    logic [DELAY_W-1:0]   delay;
  } governor_word_t;

  // Shadow copy of the load history and of the register file.
  logic [LOAD_W-1:0]   load_hist [RING_N];
  int unsigned         hist_slot;
  logic [CORE_W-1:0]   min_online;
  logic [THR_W-1:0]    enable_thr;
  logic [DPC_W-1:0]    dis_per_core;
  logic [PERIOD_W-1:0] base_period;

  governor_word_t decision_q [$];
  int unsigned    mismatches;

  // Records one sample in the history and works out the decision it leads to.
  function automatic governor_word_t predict_decision(input logic [TASK_W-1:0] tasks,
                                                      input logic [CORE_W-1:0] online);
    governor_word_t w;
    int unsigned    capped;
    int unsigned    scaled;
    int unsigned    ring_sum;
    int unsigned    avg;
    int unsigned    offline_lim;
    int unsigned    hold_delay;
    int unsigned    k;
    capped = (tasks > MAX_TASKS) ? MAX_TASKS : tasks;
    scaled = capped * LOAD_SCALE;
    if (hist_slot >= RING_N) hist_slot = 0;
    load_hist[hist_slot] = LOAD_W'(scaled);
    ring_sum = 0;
    for (k = 0; k < RING_N; k++) ring_sum += load_hist[k];
    avg = ring_sum / RING_N;
    hist_slot = (hist_slot + 1 >= RING_N) ? 0 : hist_slot + 1;

    offline_lim = dis_per_core * online;
    hold_delay  = base_period * online * online;
    w.avg   = AVG_W'(avg);
    w.delay = '0;
    if ((avg >= enable_thr && online < CORE_COUNT) || online < min_online) begin
      w.act = ACT_ONLINE_ALL;
    end else if (avg < offline_lim && online > min_online) begin
      w.act = ACT_OFFLINE_ONE;
    end else begin
      w.act   = ACT_HOLD;
      w.delay = (hold_delay > DELAY_MAX) ? DELAY_MAX : DELAY_W'(hold_delay);
    end
    return w;
  endfunction

  // Counts a failure and reports only the first few of them.
  task automatic flag_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Tracks register writes, checks result words and predicts accepted samples.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    governor_word_t    w;
    logic [CORE_W-1:0] floor_val;
    if (!rst_ni) begin
      for (int unsigned k = 0; k < RING_N; k++) load_hist[k] = '0;
      hist_slot    = 0;
      min_online   = MIN_ONLINE_RST;
      enable_thr   = ENABLE_THR_RST;
      dis_per_core = DIS_PER_CPU_RST;
      base_period  = PERIOD_RST;
      decision_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Register writes; the minimum core count is clamped to a legal range.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MIN_ONLINE: begin
            floor_val = cfg_data_i[CORE_W-1:0];
            if (floor_val < CORE_W'(1)) floor_val = CORE_W'(1);
            if (32'(floor_val) > CORE_COUNT) floor_val = CORE_W'(CORE_COUNT);
            min_online = floor_val;
          end
          CFG_ENABLE_THR:  enable_thr   = cfg_data_i[THR_W-1:0];
          CFG_DIS_PER_CPU: dis_per_core = cfg_data_i[DPC_W-1:0];
          CFG_MIN_PERIOD:  base_period  = cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // Each result word is matched against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (decision_q.size() == 0) begin
          flag_failure($sformatf("unexpected result word: action %0d avg %0d delay %0d",
                                 action_i, average_load_i, next_delay_i));
        end else begin
          w = decision_q.pop_front();
          if (action_i !== w.act || average_load_i !== w.avg || next_delay_i !== w.delay) begin
            flag_failure($sformatf({"result word mismatch: action %0d/%0d avg %0d/%0d ",
                                    "delay %0d/%0d (expected/actual)"},
                                   w.act, action_i, w.avg, average_load_i,
                                   w.delay, next_delay_i));
          end
        end
      end

      // Every accepted sample yields exactly one result word.
      if (in_valid_i && !in_stall_i) begin
        decision_q.push_back(predict_decision(runnable_tasks_i, cores_online_i));
      end

      fail_count_o <= mismatches;
      pending_o    <= decision_q.size();
    end
  end

endmodule

### bench/cpu_hotplug_load_governor_core_test.sv
`timescale 1ns / 100ps

module cpu_hotplug_load_governor_core_test;
  import chlg_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned PHASE_COUNT     = 7;
  localparam int unsigned BURST_CYCLES    = 300;
  localparam int unsigned CORNER_COUNT    = 24;

  // Corner samples run under the reset register values.
  localparam int unsigned CORNER_TASKS [CORNER_COUNT] = '{
    0, 0, 0, 0, 1, 1023, 1023, 1023, 1023, 1023, 341, 682,
    512, 511, 6, 60, 0, 0, 0, 0, 0, 0, 0, 0
  };
  localparam int unsigned CORNER_CORES [CORNER_COUNT] = '{
    1, 2, 0, 4, 3, 4, 3, 5, 6, 7, 1, 2,
    3, 4, 2, 3, 5, 6, 7, 1, 2, 3, 4, 4
  };

  // Register settings for the phases after the first, in register index order.
  // Upper data bits beyond a register's width are set in some rows on purpose.
  localparam logic [CFG_DATA_W-1:0] PHASE_CFG [PHASE_COUNT-1][4] = '{
    '{17'h10000, 17'd0,      17'd0,      17'd0},
    '{17'h00007, 17'h1FFFF,  17'h1FFFF,  17'd255},
    '{17'd2,     17'd30000,  17'd200,    17'd17},
    '{17'd3,     17'd5000,   17'h1FDF4,  17'h1FF64},
    '{17'd2,     17'h1FFFF,  17'd0,      17'd255},
    '{17'd1,     17'd1500,   17'd120,    17'd9}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TASK_W-1:0]     runnable_tasks;
  logic [CORE_W-1:0]     cores_online;
  logic                  out_valid;
  logic                  out_stall;
  logic [ACT_W-1:0]      action;
  logic [AVG_W-1:0]      average_load;
  logic [DELAY_W-1:0]    next_delay;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        burst_req;
  logic        any_accept;

  assign any_accept = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

  cpu_hotplug_load_governor_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .runnable_tasks_i (runnable_tasks),
    .cores_online_i   (cores_online),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .action_o         (action),
    .average_load_o   (average_load),
    .next_delay_o     (next_delay),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  cpu_hotplug_load_governor_core_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .runnable_tasks_i (runnable_tasks),
    .cores_online_i   (cores_online),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .action_i         (action),
    .average_load_i   (average_load),
    .next_delay_i     (next_delay),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one sample word after a random idle gap and waits until it is taken.
  task automatic send_sample(input int unsigned tasks, input int unsigned online);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    runnable_tasks <= TASK_W'(tasks);
    cores_online   <= CORE_W'(online);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off once it is requested.
  initial begin : receiver
    int unsigned hold_left;
    bit          burst_taken;
    hold_left   = 0;
    burst_taken = 1'b0;
    out_stall  <= 1'b0;
    forever begin
      @(posedge clk);
      if (burst_req && !burst_taken) begin
        hold_left   = BURST_CYCLES;
        burst_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || any_accept) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence: reset, corner samples, then random phases under several settings.
  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned r;
    int unsigned level;
    int unsigned tasks;
    int unsigned online;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    runnable_tasks <= '0;
    cores_online   <= CORE_W'(1);
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_MIN_ONLINE;
    cfg_data       <= '0;
    send_idle_pct  <= 17;
    recv_stall_pct <= 62;
    burst_req      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      // Reprogram all registers while the block is idle.
      if (phase > 0) begin
        for (r = 0; r < 4; r++) begin
          cfg_valid <= 1'b1;
          cfg_index <= cfg_reg_e'(r);
          cfg_data  <= PHASE_CFG[phase-1][r];
          @(posedge clk);
          while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
      end

      // Idling pattern: sender light and receiver heavy, then swapped, then none.
      if (phase < 3) begin
        send_idle_pct  <= 17;
        recv_stall_pct <= 62;
      end else if (phase < 5) begin
        send_idle_pct  <= 62;
        recv_stall_pct <= 17;
      end else begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      if (phase == PHASE_COUNT - 1) burst_req <= 1'b1;

      if (phase == 0) begin
        for (n = 0; n < CORNER_COUNT; n++) send_sample(CORNER_TASKS[n], CORNER_CORES[n]);
      end

      // Random samples around a slowly moving load level, with some wild ones.
      level = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 12 == 0) begin
          level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_TASKS)
                                              : $urandom_range(0, 20);
        end
        if ($urandom_range(0, 4) == 0) tasks = $urandom_range(0, MAX_TASKS);
        else tasks = level + $urandom_range(0, 4);
        if (tasks > MAX_TASKS) tasks = MAX_TASKS;
        online = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << CORE_W) - 1)
                                             : $urandom_range(1, CORE_COUNT);
        send_sample(tasks, online);
      end

      // Let every result word come back before touching the registers again.
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/chlg_pkg.sv
hdl/cpu_hotplug_load_governor_core.sv
hdl/chlg_checker.sv
bench/cpu_hotplug_load_governor_core_checker.sv
bench/cpu_hotplug_load_governor_core_test.sv
